// File: rtl/s3264_pkg.sv
// ----------------------------------------------------------------------------
// s3264_pkg: shared types, constants and functions
// Round function and key schedule step of the Simon 32/64 cipher.
// ----------------------------------------------------------------------------
package s3264_pkg;

	localparam int MAX_ROUNDS_DEF = 32;
	localparam int KEY_W          = 64;
	localparam int RCNT_W         = 6;
	localparam int BLK_W          = 32;
	localparam int WORD_W         = 16;

	localparam logic [63:0] Z0_SEQ      = 64'h19c3522fb386a45f;
	localparam logic [15:0] SCHED_CONST = 16'hFFFC;
	localparam int          Z_PERIOD    = 62;

	localparam logic [RCNT_W-1:0] RCNT_RESET = 6'd32;

	typedef logic [BLK_W-1:0]        blk_t;
	typedef logic [WORD_W-1:0]       word_t;
	// [0] is the round key used next, [3] the newest schedule word
	typedef logic [3:0][WORD_W-1:0]  keyw_t;

	typedef enum logic [0:0] {
		REG_CIPHER_KEY  = 1'b0,
		REG_ROUND_COUNT = 1'b1
	} reg_idx_t;

	// One Feistel round; result is {new left, new right}
	function automatic blk_t round_fn(blk_t blk, word_t rk);
		word_t l;
		word_t r;
		word_t f;
		l = blk[31:16];
		r = blk[15:0];
		f = ({l[14:0], l[15]} & {l[7:0], l[15:8]}) ^ {l[13:0], l[15:14]};
		return {r ^ f ^ rk, l};
	endfunction

	// Advance the key window by one word
	function automatic keyw_t key_step(keyw_t k, logic zb);
		word_t t;
		word_t knew;
		t    = {k[3][2:0], k[3][15:3]} ^ k[1];
		t    = t ^ {t[0], t[15:1]};
		knew = k[0] ^ t ^ {15'd0, zb} ^ SCHED_CONST;
		return {knew, k[3], k[2], k[1]};
	endfunction

endpackage

// File: rtl/s3264_if.sv
// ----------------------------------------------------------------------------
// s3264 stream interfaces
// Valid/ready channels for plaintext and ciphertext words.
// ----------------------------------------------------------------------------
interface s3264_pt_if;
	logic                valid;
	logic                ready;
	s3264_pkg::blk_t     plaintext_block;

	modport source (output valid, output plaintext_block, input ready);
	modport sink   (input valid, input plaintext_block, output ready);
endinterface

interface s3264_ct_if;
	logic                valid;
	logic                ready;
	s3264_pkg::blk_t     ciphertext_block;

	modport source (output valid, output ciphertext_block, input ready);
	modport sink   (input valid, input ciphertext_block, output ready);
endinterface

// File: rtl/simon_32_64_block_encrypt.sv
// ----------------------------------------------------------------------------
// simon_32_64_block_encrypt: Simon 32/64 encryption pipeline
// Unrolled round pipeline, one round per stage and one key schedule step in every stage but the last.
// ----------------------------------------------------------------------------
// Usage:
//   plain  : valid/ready sink, one 32-bit plaintext word per handshake.
//   cipher : valid/ready source, one 32-bit ciphertext word per plaintext.
//   cfg_*  : write port; index 0 is the 64-bit key, index 1 the round count
//            (values above MAX_ROUNDS act as MAX_ROUNDS). Write only while idle.
// A plaintext word passes through the MAX_ROUNDS stage registers (32 by default)
// before ciphertext valid. Throughput is one word per cycle: each of the
// stages holds one word, so a new word enters every cycle while the pipeline
// moves.
// The round keys are generated alongside the data, so each stage carries
// the four-word key window it needs; no key table is precomputed.
// Reset clears all stage valid bits, sets the key to zero and the round
// count to 32. When cipher.ready is low with a word on the output, the whole
// pipeline holds and plain.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module simon_32_64_block_encrypt #(
	parameter int MAX_ROUNDS = s3264_pkg::MAX_ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	s3264_pt_if.sink                         plain,
	s3264_ct_if.source                       cipher,
	input  logic                             cfg_wr_en,
	input  s3264_pkg::reg_idx_t              cfg_index,
	input  logic [s3264_pkg::KEY_W-1:0]      cfg_wdata
);

	localparam int RCW = $clog2(MAX_ROUNDS + 1);

	logic [s3264_pkg::KEY_W-1:0]  cipher_key_q;
	logic [s3264_pkg::RCNT_W-1:0] round_count_q;
	logic [RCW-1:0]               rounds_sat;
	logic                         adv;

	logic                valid_s [1:MAX_ROUNDS];
	s3264_pkg::blk_t     blk_s   [1:MAX_ROUNDS];
	s3264_pkg::keyw_t    key_s   [1:MAX_ROUNDS-1];
	logic [RCW-1:0]      nrnd_s  [1:MAX_ROUNDS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q  <= '0;
			round_count_q <= s3264_pkg::RCNT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				s3264_pkg::REG_CIPHER_KEY:  cipher_key_q  <= cfg_wdata;
				s3264_pkg::REG_ROUND_COUNT: round_count_q <= cfg_wdata[s3264_pkg::RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign rounds_sat = (round_count_q > s3264_pkg::RCNT_W'(MAX_ROUNDS))
		? RCW'(MAX_ROUNDS) : round_count_q[RCW-1:0];

	// Advance the whole pipeline unless the output word is stalled
	assign adv          = !valid_s[MAX_ROUNDS] || cipher.ready;
	assign plain.ready  = adv;

	assign cipher.valid            = valid_s[MAX_ROUNDS];
	assign cipher.ciphertext_block = blk_s[MAX_ROUNDS];

	for (genvar j = 1; j <= MAX_ROUNDS; j++) begin : g_stage
		localparam logic [RCW-1:0] RIDX = RCW'(j - 1);
		localparam logic           ZB   = s3264_pkg::Z0_SEQ[(j - 1) % s3264_pkg::Z_PERIOD];

		logic              src_valid;
		s3264_pkg::blk_t   src_blk;
		s3264_pkg::keyw_t  src_key;
		logic [RCW-1:0]    src_nrnd;
		s3264_pkg::blk_t   nxt_blk;

		if (j == 1) begin : g_first
			assign src_valid = plain.valid;
			assign src_blk   = plain.plaintext_block;
			assign src_key   = s3264_pkg::keyw_t'(cipher_key_q);
			assign src_nrnd  = rounds_sat;
		end else begin : g_mid
			assign src_valid = valid_s[j-1];
			assign src_blk   = blk_s[j-1];
			assign src_key   = key_s[j-1];
			assign src_nrnd  = nrnd_s[j-1];
		end

		// Skip the round once the configured count is reached
		assign nxt_blk = (RIDX < src_nrnd)
			? s3264_pkg::round_fn(src_blk, src_key[0]) : src_blk;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (adv) begin
				valid_s[j] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				blk_s[j] <= nxt_blk;
			end
		end

		if (j < MAX_ROUNDS) begin : g_key
			always_ff @(posedge clk) begin
				if (adv) begin
					key_s[j]  <= s3264_pkg::key_step(src_key, ZB);
					nrnd_s[j] <= src_nrnd;
				end
			end
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: Simon 32/64 encryption pipeline
// Streams plaintext words through the block under several key and round
// count settings. Each ciphertext word is checked in order against a local
// model of the cipher. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int DRAIN_WAIT  = 40;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 120;

	class cipher_scoreboard;
		logic [s3264_pkg::KEY_W-1:0]  key;
		logic [s3264_pkg::RCNT_W-1:0] rounds;
		s3264_pkg::blk_t              pending[$];
		int                           errors;

		function new();
			key = '0;
			rounds = s3264_pkg::RCNT_RESET;
			errors = 0;
		endfunction

		static function s3264_pkg::word_t rotl16(s3264_pkg::word_t v, int s);
			return (v << s) | (v >> (s3264_pkg::WORD_W - s));
		endfunction

		function s3264_pkg::blk_t encrypt(s3264_pkg::blk_t pt);
			s3264_pkg::word_t sched[s3264_pkg::MAX_ROUNDS_DEF];
			s3264_pkg::word_t tmp;
			s3264_pkg::word_t lw;
			s3264_pkg::word_t rw;
			s3264_pkg::word_t nl;
			int               n;
			int               i;
			for (i = 0; i < 4; i++)
				sched[i] = key[16*i +: 16];
			for (i = 4; i < s3264_pkg::MAX_ROUNDS_DEF; i++) begin
				// rotr3 and rotr1 as left rotations by 13 and 15
				tmp = rotl16(sched[i-1], 13) ^ sched[i-3];
				tmp = tmp ^ rotl16(tmp, 15);
				sched[i] = sched[i-4] ^ tmp ^ s3264_pkg::SCHED_CONST;
				sched[i][0] = sched[i][0] ^
					s3264_pkg::Z0_SEQ[(i - 4) % s3264_pkg::Z_PERIOD];
			end
			n = (rounds > s3264_pkg::MAX_ROUNDS_DEF) ? s3264_pkg::MAX_ROUNDS_DEF
				: int'(rounds);
			lw = pt[31:16];
			rw = pt[15:0];
			for (i = 0; i < n; i++) begin
				nl = rw ^ ((rotl16(lw, 1) & rotl16(lw, 8)) ^ rotl16(lw, 2)) ^ sched[i];
				rw = lw;
				lw = nl;
			end
			return {lw, rw};
		endfunction

		function void note_plain(s3264_pkg::blk_t pt);
			pending.push_back(encrypt(pt));
		endfunction

		task report(string msg);
			$display("ERROR at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_cipher(s3264_pkg::blk_t ct);
			s3264_pkg::blk_t want;
			if (pending.size() == 0) begin
				report($sformatf("ciphertext word %h with nothing outstanding", ct));
			end else begin
				want = pending.pop_front();
				if (ct !== want)
					report($sformatf("ciphertext_block %h, expected %h", ct, want));
			end
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	s3264_pkg::reg_idx_t          cfg_index;
	logic [s3264_pkg::KEY_W-1:0]  cfg_wdata;

	s3264_pt_if plain_bus ();
	s3264_ct_if cipher_bus ();

	cipher_scoreboard sb = new();

	bit gaps_on;
	bit stalls_on;
	bit long_hold_req;
	int stalled_cycles;

	simon_32_64_block_encrypt dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.plain     (plain_bus),
		.cipher    (cipher_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (plain_bus.valid === 1'b1 && plain_bus.ready === 1'b1)
			sb.note_plain(plain_bus.plaintext_block);
		if (cipher_bus.valid === 1'b1 && cipher_bus.ready === 1'b1)
			sb.check_cipher(cipher_bus.ciphertext_block);
	end

	// Call right after a rising edge; returns at the edge that takes the word.
	task automatic send_plain(s3264_pkg::blk_t pt);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		repeat (gap) begin
			@(negedge clk);
			plain_bus.valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		plain_bus.valid <= 1'b1;
		plain_bus.plaintext_block <= pt;
		do @(posedge clk); while (plain_bus.ready !== 1'b1);
	endtask

	task automatic write_reg(s3264_pkg::reg_idx_t idx,
		logic [s3264_pkg::KEY_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == s3264_pkg::REG_CIPHER_KEY)
			sb.key = value;
		else
			sb.rounds = value[s3264_pkg::RCNT_W-1:0];
	endtask

	task automatic load_config(logic [s3264_pkg::KEY_W-1:0] key,
		logic [s3264_pkg::KEY_W-1:0] rounds_word);
		write_reg(s3264_pkg::REG_CIPHER_KEY, key);
		write_reg(s3264_pkg::REG_ROUND_COUNT, rounds_word);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Drop valid and wait until every outstanding word is back.
	task automatic drain();
		@(negedge clk);
		plain_bus.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	function automatic s3264_pkg::blk_t random_block();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return s3264_pkg::blk_t'(1) << $urandom_range(0, s3264_pkg::BLK_W - 1);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [s3264_pkg::RCNT_W-1:0] random_rounds();
		case ($urandom_range(0, 9))
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd31;
			3: return 6'd33;
			4: return 6'd63;
			5, 6: return 6'd32;
			default: return $urandom_range(0, 63);
		endcase
	endfunction

	initial begin
		stalled_cycles = 0;
		while (stalled_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((plain_bus.valid === 1'b1 && plain_bus.ready === 1'b1) ||
			    (cipher_bus.valid === 1'b1 && cipher_bus.ready === 1'b1))
				stalled_cycles = 0;
			else
				stalled_cycles++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		int hold;
		cipher_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = stalls_on ? $urandom_range(0, 12) : 0;
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			repeat (hold) begin
				@(negedge clk);
				cipher_bus.ready <= 1'b0;
				@(posedge clk);
			end
			@(negedge clk);
			cipher_bus.ready <= 1'b1;
			do @(posedge clk); while (cipher_bus.valid !== 1'b1);
		end
	end

	initial begin
		s3264_pkg::blk_t              edge_words[$];
		logic [s3264_pkg::KEY_W-1:0]  key;
		logic [s3264_pkg::KEY_W-1:0]  rounds_word;
		int                           ph;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = s3264_pkg::REG_CIPHER_KEY;
		cfg_wdata = '0;
		plain_bus.valid = 1'b0;
		plain_bus.plaintext_block = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		long_hold_req = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero key, full rounds
		edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_FFFF,
			32'h8000_0000, 32'h0000_0001, 32'h0001_0000, 32'h0000_8000, 32'hAAAA_5555};
		foreach (edge_words[i])
			send_plain(edge_words[i]);
		drain();

		// Published test vector
		load_config(64'h1918_1110_0908_0100, 64'd32);
		send_plain(32'h6565_6877);
		drain();

		// Zero rounds pass the word through
		load_config('1, 64'd0);
		send_plain(32'h1234_5678);
		send_plain(32'hFFFF_FFFF);
		drain();

		// Round counts above the maximum saturate
		load_config({$urandom, $urandom}, 64'd63);
		send_plain($urandom);
		send_plain(32'h0000_0000);
		drain();

		load_config({$urandom, $urandom}, 64'd1);
		send_plain($urandom);
		send_plain(32'hFFFF_FFFF);
		drain();

		load_config({$urandom, $urandom}, {58'h3FF_FFFF_FFFF_FFFF, 6'd33});
		send_plain($urandom);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 5))
				0: key = '0;
				1: key = '1;
				default: key = {$urandom, $urandom};
			endcase
			rounds_word = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom} : '0;
			rounds_word[s3264_pkg::RCNT_W-1:0] = random_rounds();
			load_config(key, rounds_word);
			gaps_on = (ph % 3) != 1;
			stalls_on = (ph % 4) != 2;
			if (ph == 5) begin
				// hold the output long enough for the pipeline to fill
				gaps_on = 1'b0;
				long_hold_req = 1'b1;
			end
			repeat (PHASE_WORDS)
				send_plain(random_block());
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d ciphertext words never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule

// File: simon_32_64_block_encrypt.f
rtl/s3264_pkg.sv
rtl/s3264_if.sv
rtl/simon_32_64_block_encrypt.sv
tb/testbench.sv
